// ----- rtl/serial_packet_framer_core_macros.svh -----
// ----------------------------------------------------------------------------
// Serial packet framer assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PACKET_FRAMER_CORE_MACROS_SVH
`define SERIAL_PACKET_FRAMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on a given clock, held off while the reset is low.
`define SPF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on the block clock and reset.
`define SPF_ASSERT(lbl, prop, msg) \
    `SPF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define SPF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SPF_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- rtl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial packet framer package
// Action and status codes, register indexes and shared constants.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    localparam int CFG_DW        = 16;

    localparam logic [15:0] TIMEOUT_RELOAD_RST = 16'hb4;
    localparam logic [7:0]  LEN_BAD_HIGH       = 8'hff;
    localparam logic [7:0]  LEN_BAD_LOW        = 8'h00;

    typedef enum logic [2:0] {
        ACT_ARM  = 3'd0,
        ACT_RX   = 3'd1,
        ACT_SEND = 3'd2,
        ACT_TICK = 3'd3,
        ACT_WR   = 3'd4,
        ACT_RD   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        LS_OK       = 2'd0,
        LS_TIMEOUT  = 2'd1,
        LS_CHECKSUM = 2'd2,
        LS_LENGTH   = 2'd3
    } t_link_status;

    typedef enum logic {
        CFG_TIMEOUT_RELOAD   = 1'b0,
        CFG_TIMEOUT_DISABLED = 1'b1
    } t_cfg_idx;

endpackage

// ----- rtl/spf_in_if.sv -----
// ----------------------------------------------------------------------------
// Serial packet framer input channel
// Valid/ready channel carrying one action word.
// ----------------------------------------------------------------------------
interface spf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] rx_data;
    logic [7:0] buf_addr;
    logic [7:0] buf_data;

    modport source (output valid, action, rx_data, buf_addr, buf_data, input ready);
    modport sink   (input valid, action, rx_data, buf_addr, buf_data, output ready);
endinterface

// ----- rtl/spf_out_if.sv -----
// ----------------------------------------------------------------------------
// Serial packet framer result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface spf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_written;
    logic [1:0] link_status;
    logic       waiting;
    logic       tx_empty;
    logic [7:0] read_data;

    modport source (output valid, out_byte, out_written, link_status, waiting, tx_empty,
                    read_data, input ready);
    modport sink   (input valid, out_byte, out_written, link_status, waiting, tx_empty,
                    read_data, output ready);
endinterface

// ----- rtl/serial_packet_framer_core.sv -----
// Pipeline: an accepted word is held in the stage 1 register for its buffer read, then
//   commits into the result register once that register is free or draining.
// Throughput: one word per cycle while the result register drains, set by the single
//   read and write port of the packet buffer RAM; a same-entry read behind a write is forwarded, not stalled.
// Reset: synchronous, active low; clears control and link state, loads the timeout
//   reload with 180; the packet buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Serial packet framer core
// Frames length-prefixed, checksummed serial packets around one shared buffer.
// ----------------------------------------------------------------------------
`include "serial_packet_framer_core_macros.svh"

module serial_packet_framer_core #(
    parameter int BUF_DEPTH = spf_pkg::BUF_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [spf_pkg::CFG_DW-1:0] i_cfg_data,
    spf_in_if.sink                    i_item,
    spf_out_if.source                 o_out
);
    import spf_pkg::*;

    localparam int          AW        = $clog2(BUF_DEPTH);
    localparam logic [8:0]  DEPTH_LIM = 9'(BUF_DEPTH);

    // Configuration registers
    logic [15:0] r_timeout_reload;
    logic        r_timeout_disabled;

    // Link state
    logic [7:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_running_sum, n_running_sum;
    logic [7:0]  r_bad_len_cnt, n_bad_len_cnt;
    logic [1:0]  r_status, n_status;
    logic        r_in_progress, n_in_progress;
    logic [15:0] r_timer, n_timer;

    // Stage 1: word waiting for its buffer read data
    logic        r_s1_valid;
    logic [2:0]  r_s1_act;
    logic [7:0]  r_s1_rx;
    logic [7:0]  r_s1_addr;
    logic [7:0]  r_s1_data;
    logic        r_s1_rd_ok;
    logic        r_s1_fwd_hit;
    logic [7:0]  r_s1_fwd_data;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_written, n_out_written;
    logic [1:0]  r_link_status;
    logic        r_waiting;
    logic        r_tx_empty, n_tx_empty;
    logic [7:0]  r_read_data, n_read_data;

    // Handshake and buffer port
    logic        out_free;
    logic        s1_commit;
    logic        in_accept;
    logic        wr_en;
    logic [7:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  rd_addr;
    logic        rd_ok;
    logic        rd_needed;
    logic [7:0]  ram_rdata;
    logic [7:0]  s1_q;

    // Working values
    logic        idx_ok;
    logic [7:0]  len_v;
    logic [7:0]  sum_v;
    logic [7:0]  left_v;
    logic [7:0]  cnt_v;
    logic [15:0] tmr_v;

    // Hold stage 1 while the result register is occupied and not drained.
    assign out_free  = !r_out_valid || o_out.ready;
    assign s1_commit = r_s1_valid && out_free;
    assign i_item.ready = !r_s1_valid || out_free;
    assign in_accept = i_item.valid && i_item.ready;

    // Buffer data for the word in stage 1; out-of-range reads give zero.
    assign s1_q = r_s1_rd_ok ? (r_s1_fwd_hit ? r_s1_fwd_data : ram_rdata) : 8'd0;

    // Step the link state for the word in stage 1.
    always_comb begin
        n_byte_index  = r_byte_index;
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        n_bad_len_cnt = r_bad_len_cnt;
        n_status      = r_status;
        n_in_progress = r_in_progress;
        n_timer       = r_timer;
        n_out_byte    = 8'd0;
        n_out_written = 1'b0;
        n_tx_empty    = 1'b0;
        n_read_data   = 8'd0;
        wr_en         = 1'b0;
        wr_addr       = r_byte_index;
        wr_data       = r_s1_rx;
        idx_ok        = {1'b0, r_byte_index} < DEPTH_LIM;
        len_v         = 8'd0;
        sum_v         = 8'd0;
        left_v        = 8'd0;
        cnt_v         = 8'd0;
        tmr_v         = 16'd0;

        if (s1_commit) begin
            unique case (r_s1_act)
                ACT_ARM: begin
                    n_byte_index  = 8'd0;
                    n_status      = LS_OK;
                    n_running_sum = 8'd0;
                    n_bad_len_cnt = 8'd0;
                    n_in_progress = 1'b1;
                    n_timer       = r_timeout_reload;
                end
                ACT_RX: begin
                    n_in_progress = 1'b1;
                    n_status      = LS_OK;
                    n_timer       = r_timeout_reload;
                    if (r_byte_index == 8'd0 &&
                        (r_s1_rx == LEN_BAD_HIGH || r_s1_rx == LEN_BAD_LOW)) begin
                        // Reject the length byte; count unless timeouts are off.
                        if (!r_timeout_disabled) begin
                            cnt_v         = r_bad_len_cnt + 8'd1;
                            n_bad_len_cnt = cnt_v;
                            if (cnt_v == 8'd0) begin
                                n_status      = LS_LENGTH;
                                n_in_progress = 1'b0;
                            end
                        end
                    end else begin
                        len_v        = (r_byte_index == 8'd0) ? r_s1_rx : r_bytes_left;
                        left_v       = len_v - 8'd1;
                        n_bytes_left = left_v;
                        if (left_v == 8'd0) begin
                            // Checksum byte closes the packet.
                            if (r_s1_rx != r_running_sum) begin
                                n_status = LS_CHECKSUM;
                            end
                            n_in_progress = 1'b0;
                        end else begin
                            wr_en         = idx_ok;
                            n_byte_index  = r_byte_index + 8'd1;
                            n_running_sum = r_running_sum + r_s1_rx;
                        end
                        n_bad_len_cnt = 8'd0;
                        n_out_written = 1'b1;
                    end
                end
                ACT_SEND: begin
                    if (r_byte_index == 8'd0 && s1_q == 8'd0) begin
                        n_tx_empty = 1'b1;
                    end else begin
                        len_v        = (r_byte_index == 8'd0) ? s1_q : r_bytes_left;
                        sum_v        = (r_byte_index == 8'd0) ? 8'd0 : r_running_sum;
                        left_v       = len_v - 8'd1;
                        n_bytes_left = left_v;
                        n_byte_index = r_byte_index + 8'd1;
                        if (left_v != 8'd0) begin
                            n_out_byte = s1_q;
                        end else begin
                            // Trailer: put the running sum out as the checksum.
                            n_in_progress = 1'b0;
                            n_out_byte    = sum_v;
                        end
                        n_out_written = 1'b1;
                        n_running_sum = sum_v + n_out_byte;
                    end
                end
                ACT_TICK: begin
                    if (!r_timeout_disabled) begin
                        tmr_v   = (r_timer != 16'd0) ? (r_timer - 16'd1) : r_timer;
                        n_timer = tmr_v;
                        if (tmr_v == 16'd0) begin
                            n_in_progress = 1'b0;
                            n_status      = LS_TIMEOUT;
                        end
                    end
                end
                ACT_WR: begin
                    wr_en   = {1'b0, r_s1_addr} < DEPTH_LIM;
                    wr_addr = r_s1_addr;
                    wr_data = r_s1_data;
                end
                ACT_RD: begin
                    n_read_data = s1_q;
                end
                default: begin
                end
            endcase
        end
    end

    // Read at the index the previous word leaves behind, or at the given address.
    assign rd_addr   = (i_item.action == ACT_SEND) ? n_byte_index : i_item.buf_addr;
    assign rd_ok     = {1'b0, rd_addr} < DEPTH_LIM;
    assign rd_needed = (i_item.action == ACT_SEND) || (i_item.action == ACT_RD);

    spf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (in_accept && rd_ok && rd_needed),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_reload   <= TIMEOUT_RELOAD_RST;
            r_timeout_disabled <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT_RELOAD:   r_timeout_reload   <= i_cfg_data[15:0];
                CFG_TIMEOUT_DISABLED: r_timeout_disabled <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Control and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= 8'd0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
            r_bad_len_cnt <= 8'd0;
            r_status      <= LS_OK;
            r_in_progress <= 1'b0;
            r_timer       <= 16'd0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_byte_index  <= n_byte_index;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
            r_bad_len_cnt <= n_bad_len_cnt;
            r_status      <= n_status;
            r_in_progress <= n_in_progress;
            r_timer       <= n_timer;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: stage 1 word and result word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_act      <= i_item.action;
            r_s1_rx       <= i_item.rx_data;
            r_s1_addr     <= i_item.buf_addr;
            r_s1_data     <= i_item.buf_data;
            r_s1_rd_ok    <= rd_ok;
            // Forward a write landing in the same cycle as this read.
            r_s1_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_s1_fwd_data <= wr_data;
        end
        if (s1_commit) begin
            r_out_byte    <= n_out_byte;
            r_out_written <= n_out_written;
            r_link_status <= n_status;
            r_waiting     <= n_in_progress;
            r_tx_empty    <= n_tx_empty;
            r_read_data   <= n_read_data;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.out_written = r_out_written;
    assign o_out.link_status = r_link_status;
    assign o_out.waiting     = r_waiting;
    assign o_out.tx_empty    = r_tx_empty;
    assign o_out.read_data   = r_read_data;

    // A stalled stage 1 word must keep its action until it commits.
    `SPF_ASSERT(a_s1_hold, r_s1_valid && !s1_commit |=> r_s1_valid && $stable(r_s1_act), "stage 1 word lost while stalled")
    // Timeout and length error always end the packet.
    `SPF_ASSERT(a_err_idle, o_out.valid && (o_out.link_status == LS_TIMEOUT || o_out.link_status == LS_LENGTH) |-> !o_out.waiting, "error status with packet in progress")
    // An empty send never drives the data register.
    `SPF_ASSERT(a_empty_nowr, o_out.valid && o_out.tx_empty |-> !o_out.out_written && o_out.out_byte == 8'd0, "empty send wrote a byte")
    // Nonzero buffer read data never overlaps with a serial byte or an empty send.
    `SPF_ASSERT(a_rd_only, o_out.valid && o_out.read_data != 8'd0 |-> !o_out.out_written && !o_out.tx_empty, "read data with serial output")
endmodule

// ----- rtl/spf_ram.sv -----
// ----------------------------------------------------------------------------
// Serial packet framer RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
